>>> rtl/assert_macros.svh
// Assertion macros for the RTL files; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/npcm_pkg.sv
// Shared types, constants and color helpers for the palette color mapper.
package npcm_pkg;

    localparam int PALETTE_DEPTH_DEF = 16;
    localparam int RGB_W             = 24;
    localparam int SLOT_W            = 4;
    localparam int INDEX_W           = 4;
    localparam int COUNT_W           = 5;
    localparam int DIST_W            = 14;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MAP   = 1'b1;

    typedef struct packed {
        logic              op;
        logic [RGB_W-1:0]  pixel_rgb;
        logic [RGB_W-1:0]  entry_rgb;
        logic [SLOT_W-1:0] slot;
    } t_in_item;

    typedef struct packed {
        logic [RGB_W-1:0]   mapped_rgb;
        logic [INDEX_W-1:0] palette_index;
    } t_out_item;

    typedef struct packed {
        logic write;
        logic load;
        logic rd;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_status;

    function automatic logic [4:0] red5(input logic [RGB_W-1:0] rgb);
        return rgb[23:19];
    endfunction

    function automatic logic [5:0] green6(input logic [RGB_W-1:0] rgb);
        return rgb[15:10];
    endfunction

    function automatic logic [4:0] blue5(input logic [RGB_W-1:0] rgb);
        return rgb[7:3];
    endfunction

endpackage

>>> rtl/npcm_ctrl.sv
// Controller: sequences palette writes and the entry-by-entry search.
module npcm_ctrl import npcm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_op,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST
    } t_state;

    t_state r_state, n_state;
    logic   r_busy,  n_busy;
    logic   accept;

    assign accept = i_start && !r_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_op == OP_MAP) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    always_comb begin
        o_cmd.write  = accept && i_op == OP_WRITE;
        o_cmd.load   = accept && i_op == OP_MAP;
        o_cmd.rd     = (r_state == S_SCAN);
        o_cmd.finish = (r_state == S_LAST);
    end

    assign o_busy = r_busy;

endmodule

>>> rtl/npcm_datapath.sv
// Datapath: palette memory, distance unit, best-match tracking, result register.
module npcm_datapath import npcm_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    input  t_in_item           i_item,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    output t_out_item          o_result,
    output logic               o_valid
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [RGB_W-1:0]   mem [PALETTE_DEPTH];

    logic [COUNT_W-1:0] r_count;
    logic [4:0]         r_pr, r_pb;
    logic [5:0]         r_pg;
    logic [AW-1:0]      r_addr, r_last;
    logic [RGB_W-1:0]   r_rd_data;
    logic [AW-1:0]      r_rd_idx;
    logic               r_rd_vld;
    logic [DIST_W-1:0]  r_best;
    logic [AW-1:0]      r_best_idx;
    logic [RGB_W-1:0]   r_best_rgb;
    t_out_item          r_out;
    logic               r_out_vld;

    logic [COUNT_W-1:0] act_cnt;
    logic [AW-1:0]      n_last;
    logic [4:0]         dr, db;
    logic [5:0]         dg;
    logic [DIST_W-1:0]  sq_sum;
    logic               take;
    logic [DIST_W-1:0]  n_best;
    logic [AW-1:0]      n_best_idx;
    logic [RGB_W-1:0]   n_best_rgb;
    logic               slot_ok;

    // Active entry count: zero reads as one, saturate at depth.
    always_comb begin
        if (r_count == '0) begin
            act_cnt = COUNT_W'(1);
        end else if (32'(r_count) > 32'(PALETTE_DEPTH)) begin
            act_cnt = COUNT_W'(PALETTE_DEPTH);
        end else begin
            act_cnt = r_count;
        end
        n_last = AW'(act_cnt - COUNT_W'(1));
    end

    assign slot_ok = 32'(i_item.slot) < 32'(PALETTE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && slot_ok) begin
            mem[AW'(i_item.slot)] <= i_item.entry_rgb;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_addr];
            r_rd_idx  <= r_addr;
        end
    end

    always_comb begin
        dr   = (r_pr > red5(r_rd_data)) ? r_pr - red5(r_rd_data) : red5(r_rd_data) - r_pr;
        dg   = (r_pg > green6(r_rd_data)) ? r_pg - green6(r_rd_data)
                                          : green6(r_rd_data) - r_pg;
        db   = (r_pb > blue5(r_rd_data)) ? r_pb - blue5(r_rd_data) : blue5(r_rd_data) - r_pb;
        sq_sum = DIST_W'(dr) * DIST_W'(dr) + DIST_W'(dg) * DIST_W'(dg)
               + DIST_W'(db) * DIST_W'(db);
        // First entry always wins; later ones only on a strictly smaller distance.
        take = r_rd_vld && (r_rd_idx == '0 || sq_sum < r_best);
        n_best     = take ? sq_sum    : r_best;
        n_best_idx = take ? r_rd_idx  : r_best_idx;
        n_best_rgb = take ? r_rd_data : r_best_rgb;
    end

    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_best_rgb <= n_best_rgb;
        if (i_cmd.load) begin
            r_pr   <= red5(i_item.pixel_rgb);
            r_pg   <= green6(i_item.pixel_rgb);
            r_pb   <= blue5(i_item.pixel_rgb);
            r_last <= n_last;
        end
        if (i_cmd.finish) begin
            r_out.mapped_rgb    <= n_best_rgb;
            r_out.palette_index <= INDEX_W'(n_best_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= COUNT_RESET;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_addr <= '0;
            end else if (i_cmd.rd) begin
                r_addr <= r_addr + AW'(1);
            end
            r_rd_vld  <= i_cmd.rd;
            r_out_vld <= i_cmd.finish;
        end
    end

    assign o_status.last = (r_addr == r_last);
    assign o_result      = r_out;
    assign o_valid       = r_out_vld;

endmodule

>>> rtl/nearest_palette_color_map_unit.sv
// Top level of the nearest palette color mapper.
//
//  channel   direction  transfer when            payload
//  item      in         start && !busy           i_item  (t_in_item)
//  result    out        o_valid (one cycle)      o_result (t_out_item)
//  config    in         i_cfg_we                 i_cfg_wdata (palette_count)
//
//  A write item updates the palette memory; busy stays low and no result follows.
//  A map item scans N entries, N the active entry count (1..PALETTE_DEPTH): one palette
//  memory read per cycle feeds the single distance-and-compare unit.
//  o_valid rises in the cycle busy falls; a new item may start in that cycle.
//  The receiver cannot stall; the result strobe lasts exactly one cycle.
//  Synchronous active-low reset; palette contents are not cleared.
`include "assert_macros.svh"
module nearest_palette_color_map_unit import npcm_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_item           i_item,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    output logic               o_valid,
    output t_out_item          o_result
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       map_xfer;
    logic       write_xfer;

    npcm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_item.op),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    npcm_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (o_result),
        .o_valid     (o_valid)
    );

    assign map_xfer   = start && !busy && i_item.op == OP_MAP;
    assign write_xfer = start && !busy && i_item.op == OP_WRITE;

    `ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !busy && !o_valid, "not idle after reset")
    `ASSERT_SYNC(a_map_busy, i_clk, i_rst_n, map_xfer |=> busy, "map transfer did not raise busy")
    `ASSERT_SYNC(a_write_idle, i_clk, i_rst_n, write_xfer |=> !busy, "write transfer raised busy")
    `ASSERT_SYNC(a_done_result, i_clk, i_rst_n, $fell(busy) |-> o_valid, "no result at search end")
    `ASSERT_SYNC(a_valid_pulse, i_clk, i_rst_n, o_valid |=> !o_valid, "strobe longer than one cycle")

endmodule
